// ===== rtl/core/rfd_pkg.sv =====
// Shared constants and controller/datapath interface types for the rail fence decrypter.
package rfd_pkg;

	localparam int MAX_RAILS   = 16;
	localparam int MIN_RAILS   = 2;
	localparam int RAILS_W     = 5;
	localparam int ROW_W       = 4;
	localparam int SUB_W       = 2;
	localparam int CHAR_W      = 8;
	localparam int COL_W       = 6;
	localparam int STORE_DEPTH = 64;

	localparam logic [RAILS_W-1:0] RAILS_RESET = RAILS_W'(MIN_RAILS);
	localparam logic [CHAR_W-1:0]  PAD_CHAR    = 8'h58;

	// controller -> datapath
	typedef struct packed {
		logic load;      // write input byte, advance load position
		logic rd_start;  // read column 0
		logic rd_next;   // read the column after the current one
		logic hold_ld;   // capture read data into hold register
		logic out_ld;    // move hold register into the output register
		logic out_final; // last-byte mark for out_ld
	} rfd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic frame_end; // load position is the last byte of the frame
		logic pad;       // read data is the padding character
		logic ptr_last;  // read data is the last column of the frame
		logic out_free;  // output register can take a byte this cycle
	} rfd_status_t;

endpackage

// ===== rtl/core/rfd_datapath.sv =====
// Datapath: rails register, load position, column store, read pointer and output register.
module rfd_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rfd_pkg::RAILS_W-1:0] cfg_wdata,
	input  logic [rfd_pkg::CHAR_W-1:0]  in_char,
	input  rfd_pkg::rfd_cmd_t           cmd,
	output rfd_pkg::rfd_status_t        status,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rfd_pkg::CHAR_W-1:0]  out_char,
	output logic                        out_final
);
	import rfd_pkg::*;

	logic [RAILS_W-1:0] rails_q;
	logic [ROW_W-1:0]   row_q;
	logic [SUB_W-1:0]   sub_q;
	logic [COL_W-1:0]   rd_ptr_q;
	logic [CHAR_W-1:0]  rdata_q;
	logic [CHAR_W-1:0]  hold_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_final_q;
	logic [CHAR_W-1:0]  mem [STORE_DEPTH];

	logic [RAILS_W-1:0] eff_r;
	logic [ROW_W-1:0]   last_row;
	logic [COL_W-1:0]   period;
	logic [COL_W-1:0]   period2;
	logic [COL_W-1:0]   k;
	logic [COL_W-1:0]   wr_col;
	logic [COL_W-1:0]   rd_addr;
	logic               rd_en;

	// clamp rails into 2..MAX_RAILS
	always_comb begin
		if (rails_q < RAILS_W'(MIN_RAILS)) begin
			eff_r = RAILS_W'(MIN_RAILS);
		end else if (rails_q > RAILS_W'(MAX_RAILS)) begin
			eff_r = RAILS_W'(MAX_RAILS);
		end else begin
			eff_r = rails_q;
		end
	end

	assign last_row = ROW_W'(eff_r - RAILS_W'(1));
	assign period   = COL_W'({eff_r, 1'b0}) - COL_W'(2);
	assign period2  = {period[COL_W-2:0], 1'b0};
	assign k        = COL_W'(row_q);

	// column filled by the current load position
	always_comb begin
		if (row_q == '0) begin
			case (sub_q)
				2'd0:    wr_col = '0;
				2'd1:    wr_col = period;
				default: wr_col = period2;
			endcase
		end else if (row_q == last_row) begin
			case (sub_q)
				2'd0:    wr_col = k;
				default: wr_col = period + k;
			endcase
		end else begin
			case (sub_q)
				2'd0:    wr_col = k;
				2'd1:    wr_col = period - k;
				2'd2:    wr_col = period + k;
				default: wr_col = period2 - k;
			endcase
		end
	end

	assign status.frame_end = (row_q == last_row) && (sub_q == SUB_W'(1));
	assign status.pad       = (rdata_q == PAD_CHAR);
	assign status.ptr_last  = (rd_ptr_q == period2);
	assign status.out_free  = !out_valid_q || out_ready;

	assign rd_en   = cmd.rd_start || cmd.rd_next;
	assign rd_addr = cmd.rd_start ? '0 : rd_ptr_q + COL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rails_q     <= RAILS_RESET;
			row_q       <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rails_q <= cfg_wdata;
				row_q   <= '0;
				sub_q   <= '0;
			end else if (cmd.load) begin
				if (status.frame_end) begin
					row_q <= '0;
					sub_q <= '0;
				end else if ((row_q == '0 && sub_q == SUB_W'(2)) || sub_q == SUB_W'(3)) begin
					row_q <= row_q + ROW_W'(1);
					sub_q <= '0;
				end else begin
					sub_q <= sub_q + SUB_W'(1);
				end
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_ptr_q <= rd_addr;
		end
		if (cmd.hold_ld) begin
			hold_q <= rdata_q;
		end
		if (cmd.out_ld) begin
			out_char_q  <= hold_q;
			out_final_q <= cmd.out_final;
		end
	end

	// column store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[wr_col] <= in_char;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_final = out_final_q;

endmodule

// ===== rtl/core/rfd_ctrl.sv =====
// Controller: load / emit sequencing state machine.
module rfd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rfd_pkg::rfd_status_t status,
	output rfd_pkg::rfd_cmd_t    cmd
);
	import rfd_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_FIRST,
		ST_NEXT,
		ST_LAST
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_LOAD);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.frame_end) begin
						cmd.rd_start = 1'b1;
						state_d      = ST_FIRST;
					end
				end
			end
			ST_FIRST: begin
				// leading pad: frame gives nothing
				if (status.pad) begin
					state_d = ST_LOAD;
				end else begin
					cmd.hold_ld = 1'b1;
					cmd.rd_next = 1'b1;
					state_d     = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (status.out_free) begin
					cmd.out_ld    = 1'b1;
					cmd.out_final = status.pad;
					if (status.pad) begin
						state_d = ST_LOAD;
					end else begin
						cmd.hold_ld = 1'b1;
						if (status.ptr_last) begin
							state_d = ST_LAST;
						end else begin
							cmd.rd_next = 1'b1;
						end
					end
				end
			end
			ST_LAST: begin
				if (status.out_free) begin
					cmd.out_ld    = 1'b1;
					cmd.out_final = 1'b1;
					state_d       = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/rail_fence_two_cycle_decrypt.sv =====
// Top level of the rail fence frame decrypter: controller plus datapath.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata[7:0] = cipher_char
//  m_*       out  m_tvalid/m_tready  m_tdata[7:0] = plain_char, m_tlast = final_char
//  cfg_*     in   cfg_we             cfg_wdata[4:0] = rails
//
// Loading takes one transaction per cycle; a frame is 4*rails-3 bytes (rails clamped
// to 2..16). After the last byte, input is blocked while the column store is read
// back in order: column 0 is fetched first, then one output byte per cycle, set by
// the single read port of the store, while m_tready is high.
// Emission stops before the first 'X'; the last byte carries m_tlast.
// Reset clears the load position, the state machine and the output valid; rails = 2.
// A rails write restarts the frame.
module rail_fence_two_cycle_decrypt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] cipher_char
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,   // [7:0] plain_char
	output logic                        m_tlast,   // final_char
	input  logic                        cfg_we,
	input  logic [rfd_pkg::RAILS_W-1:0] cfg_wdata  // rails
);
	import rfd_pkg::*;

	rfd_cmd_t    cmd;
	rfd_status_t status;

	// sequencing: accepts input only while loading, drives read-back
	rfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// store, position counters and output register
	rfd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_char   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_final (m_tlast)
	);

endmodule

// ===== test/rfd_plain_checker.sv =====
// Channel monitor for the rail fence decrypter: predicts plaintext per frame and checks it.
`timescale 1ns / 1ps

module rfd_plain_checker
	import rfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [CHAR_W-1:0]  s_tdata,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [CHAR_W-1:0]  m_tdata,
	input  logic               m_tlast,
	input  logic               cfg_we,
	input  logic [RAILS_W-1:0] cfg_wdata,
	output int                 fail_count,
	output int                 pending_plain
);

	typedef struct packed {
		logic [CHAR_W-1:0] plain;
		logic              last;
	} plain_beat_t;

	plain_beat_t        expected_plain[$];
	logic [RAILS_W-1:0] rails_reg;
	logic [COL_W-1:0]   load_pos;
	logic [CHAR_W-1:0]  column_store [STORE_DEPTH];

	initial begin
		fail_count    = 0;
		pending_plain = 0;
	end

	function automatic int unsigned active_rails(input logic [RAILS_W-1:0] v);
		int unsigned r;
		r = v;
		if (r < MIN_RAILS) r = MIN_RAILS;
		if (r > MAX_RAILS) r = MAX_RAILS;
		return r;
	endfunction

	// plaintext column filled by load position pos: rows are loaded one after another
	function automatic int unsigned zigzag_column(input int unsigned pos, input int unsigned r);
		int unsigned period, m, k, col;
		period = 2 * r - 2;
		if (pos < 3) begin
			col = pos * period;
		end else begin
			m = pos - 3;
			if (m < 4 * (r - 2)) begin
				k = 1 + m / 4;
				case (m % 4)
					0: col = k;
					1: col = period - k;
					2: col = period + k;
					default: col = 2 * period - k;
				endcase
			end else begin
				col = (m == 4 * (r - 2)) ? r - 1 : 3 * r - 3;
			end
		end
		return col;
	endfunction

	// read back in column order up to the first pad; the last byte out carries tlast
	task automatic predict_plaintext(input int unsigned flen);
		int unsigned stop;
		stop = 0;
		while (stop < flen && column_store[stop] != PAD_CHAR) stop++;
		for (int unsigned c = 0; c < stop; c++)
			expected_plain.push_back(plain_beat_t'{column_store[c], c == stop - 1});
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns: MISMATCH %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		plain_beat_t beat;
		int unsigned r, flen;
		if (!arst_n) begin
			rails_reg = RAILS_RESET;
			load_pos  = '0;
			expected_plain.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_plain.size() == 0) begin
					report_mismatch($sformatf("output %02h with no byte expected", m_tdata));
				end else begin
					beat = expected_plain.pop_front();
					if (m_tdata !== beat.plain)
						report_mismatch($sformatf("plain_char %02h, expected %02h",
							m_tdata, beat.plain));
					if (m_tlast !== beat.last)
						report_mismatch($sformatf("final_char %b, expected %b on byte %02h",
							m_tlast, beat.last, beat.plain));
				end
			end
			// a rails write drops any partly loaded frame
			if (cfg_we) begin
				rails_reg = cfg_wdata;
				load_pos  = '0;
			end
			if (s_tvalid && s_tready) begin
				r    = active_rails(rails_reg);
				flen = 4 * r - 3;
				column_store[zigzag_column(load_pos, r)] = s_tdata;
				load_pos = load_pos + 1'b1;
				if (load_pos == flen) begin
					load_pos = '0;
					predict_plaintext(flen);
				end
			end
		end
		pending_plain = expected_plain.size();
	end

endmodule

// ===== test/tb_rail_fence_two_cycle_decrypt.sv =====
// Stimulus and verdict for the rail fence decrypter, checked by rfd_plain_checker.
`timescale 1ns / 1ps

module tb_rail_fence_two_cycle_decrypt;
	import rfd_pkg::*;

	localparam int ITEM_TARGET = 440;  // random phase stops here; the last round of frames runs past it
	localparam int IDLE_SETTLE = 8;    // covers the column 0 fetch of a frame with no output

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [CHAR_W-1:0]  s_tdata   = '0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [CHAR_W-1:0]  m_tdata;
	logic               m_tlast;
	logic               cfg_we    = 1'b0;
	logic [RAILS_W-1:0] cfg_wdata = '0;

	int fail_count;
	int pending_plain;

	int burst_left = 0;
	int gap_max    = 4;
	int cur_len    = 4 * MIN_RAILS - 3;
	int sent_count = 0;
	int stall_tick = 0;
	int stall_mode = 0;

	rail_fence_two_cycle_decrypt dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rfd_plain_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending_plain (pending_plain)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: a randomly redrawn mode, from always ready to heavy stalls
	always @(negedge clk) begin
		if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
		stall_tick++;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (stall_tick % 5 != 0);
		endcase
	end

	function automatic int frame_len_for(input logic [RAILS_W-1:0] v);
		int r;
		r = v;
		if (r < MIN_RAILS) r = MIN_RAILS;
		if (r > MAX_RAILS) r = MAX_RAILS;
		return 4 * r - 3;
	endfunction

	// one input transaction; bursts of random length with random gaps between them
	task automatic send_cipher(input logic [CHAR_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 24);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	// hold off the sender until every expected byte is out and the block is quiet
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_plain != 0) @(negedge clk);
		repeat (IDLE_SETTLE) @(negedge clk);
	endtask

	task automatic write_rails(input logic [RAILS_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we  <= 1'b0;
		cur_len = frame_len_for(v);
	endtask

	// random frame content: sometimes leading pad, sometimes a pad somewhere inside;
	// n_send below cur_len leaves the frame broken off
	task automatic send_frame(input int n_send);
		logic [CHAR_W-1:0] frame_bytes [STORE_DEPTH];
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < cur_len; i++) frame_bytes[i] = CHAR_W'($urandom_range(0, 255));
		if (kind < 2)
			frame_bytes[0] = PAD_CHAR;
		else if (kind < 5)
			frame_bytes[$urandom_range(1, cur_len - 1)] = PAD_CHAR;
		for (int i = 0; i < n_send; i++) send_cipher(frame_bytes[i]);
	endtask

	initial begin : stimulus
		logic [RAILS_W-1:0] rails_val;
		int pick, n_frames;
		bit first_phase;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset rails value, frame of 5 with no pad: all five out, last one marked
		send_cipher(8'h00);
		send_cipher(8'hFF);
		send_cipher(8'h80);
		send_cipher(8'h7F);
		send_cipher(8'h01);
		// leading pad: frame gives nothing
		send_cipher(PAD_CHAR);
		send_cipher(8'hFF);
		send_cipher(8'h00);
		send_cipher(8'hAA);
		send_cipher(8'h55);
		// rails below range clamps to 2; pad lands on column 1, so one byte comes out
		write_rails(5'd0);
		send_cipher(8'h41);
		send_cipher(8'h42);
		send_cipher(8'h43);
		send_cipher(PAD_CHAR);
		send_cipher(8'h44);
		// rails write in the middle of a frame restarts it
		send_cipher(8'h61);
		send_cipher(8'h62);
		send_cipher(8'h63);
		write_rails(5'd3);
		for (int i = 0; i < cur_len; i++) send_cipher(CHAR_W'(8'h30 + i));

		first_phase = 1'b1;
		while (sent_count < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (first_phase)
				rails_val = 5'd31;  // above range, clamps to the largest frame
			else if (pick < 5)
				rails_val = RAILS_W'($urandom_range(2, 5));
			else if (pick < 7)
				rails_val = RAILS_W'($urandom_range(6, 15));
			else if (pick < 8)
				rails_val = RAILS_W'(MAX_RAILS);
			else
				rails_val = RAILS_W'($urandom_range(0, 31));
			first_phase = 1'b0;
			write_rails(rails_val);
			gap_max  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			n_frames = (cur_len > 17) ? $urandom_range(1, 2) : $urandom_range(2, 8);
			for (int f = 0; f < n_frames; f++) begin
				if ($urandom_range(0, 7) == 0) settle();
				send_frame(cur_len);
			end
			if ($urandom_range(0, 5) == 0) send_frame($urandom_range(1, cur_len - 1));
		end

		settle();
		repeat (16) @(negedge clk);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/rfd_pkg.sv
rtl/core/rfd_datapath.sv
rtl/core/rfd_ctrl.sv
rtl/core/rail_fence_two_cycle_decrypt.sv
test/rfd_plain_checker.sv
test/tb_rail_fence_two_cycle_decrypt.sv
